### sv/battery_average_alarm_core_macros.svh
// Assertion macros for the battery average alarm core.
// Used by the top level only; holds nothing but macro definitions.
`ifndef BATTERY_AVERAGE_ALARM_CORE_MACROS_SVH
`define BATTERY_AVERAGE_ALARM_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/baa_pkg.sv
// Shared types and constants for the battery average alarm core.
// No dependencies.
package baa_pkg;
  localparam int unsigned WindowLimit = 360;
  localparam int unsigned NumStations = 16;
  localparam int unsigned RingSize    = WindowLimit + 1;
  localparam int unsigned StW  = 4;
  localparam int unsigned SmpW = 16;
  localparam int unsigned SumW = 25;
  localparam int unsigned CntW = $clog2(RingSize + 1);
  localparam int unsigned PtrW = $clog2(RingSize);
  localparam int unsigned MemDepth = NumStations * RingSize;
  localparam int unsigned MemAw = $clog2(MemDepth);
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw = 1;
  localparam logic signed [SmpW-1:0] ThresholdReset = 16'sd2400;

  typedef enum logic [1:0] {
    NOTICE_NONE = 2'd0,
    NOTICE_LOW  = 2'd1,
    NOTICE_OK   = 2'd2
  } notice_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_WAIT, BK_DIV, BK_DONE
  } back_state_e;

  // Classified work item passed from front to back.
  typedef struct packed {
    logic [StW-1:0]         station;
    logic signed [SmpW-1:0] sample;
    logic                   in_range;
  } work_t;
endpackage

### sv/baa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module baa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### sv/baa_front.sv
// Front end: accepts samples, classifies the station and queues work.
// Depends on baa_pkg.
module baa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        station_i,
  input  logic signed [15:0] sample_i,
  output logic              work_valid_o,
  input  logic              work_pop_i,
  output baa_pkg::work_t    work_o
);
  import baa_pkg::*;

  work_t          q_mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;
  logic           push;
  work_t          item;

  assign in_stall_o   = (cnt_q == (QAw+1)'(QDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign work_valid_o = (cnt_q != '0);
  assign work_o       = q_mem_q[rd_q];

  always_comb begin
    item.station  = station_i;
    item.sample   = sample_i;
    item.in_range = ({28'd0, station_i} < 32'(NumStations));
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (work_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(work_pop_i);
    end
  end
endmodule

### sv/baa_div.sv
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// Depends on baa_pkg.
module baa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [baa_pkg::SumW-1:0] num_i,
  input  logic [baa_pkg::CntW-1:0]   den_i,
  output logic                       done_o,
  output logic signed [baa_pkg::SmpW-1:0] quot_o
);
  import baa_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [SumW:0]    rem_q, rem_d;
  logic [CntW-1:0]  den_q;
  logic             neg_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [SumW:0]    trial;
  logic [SumW-1:0]  mag;
  logic [SumW-1:0]  signed_q;

  assign mag = num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);

  always_comb begin
    trial = {rem_q[SumW-1:0], quo_q[SumW-1]};
    rem_d = trial;
    quo_d = {quo_q[SumW-2:0], 1'b0};
    if (trial >= (SumW+1)'(den_q)) begin
      rem_d    = trial - (SumW+1)'(den_q);
      quo_d[0] = 1'b1;
    end
  end

  assign signed_q = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o   = signed_q[SmpW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[SumW-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end
endmodule

### sv/baa_back.sv
// Back end: per-station window update, average and notice logic.
// Depends on baa_pkg, baa_ram and baa_div.
module baa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [15:0] threshold_i,
  input  logic              work_valid_i,
  output logic              work_pop_o,
  input  baa_pkg::work_t    work_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        station_out_o,
  output logic signed [15:0] average_o,
  output logic              low_alert_o,
  output logic [1:0]        notice_o
);
  import baa_pkg::*;

  back_state_e state_q, state_d;
  logic signed [SumW-1:0] sum_q [NumStations];
  logic [CntW-1:0] cnt_q [NumStations];
  logic [PtrW-1:0] head_q [NumStations];
  logic [NumStations-1:0] flag_q;

  work_t           cur_q;
  logic [CntW-1:0] ncnt_q;
  logic [PtrW-1:0] nhead_q;
  logic            drop_q;
  logic            mem_we;
  logic [MemAw-1:0] mem_addr;
  logic [SmpW-1:0] mem_rdata;
  logic signed [SumW-1:0] new_sum;
  logic            div_start, div_done;
  logic signed [SmpW-1:0] quot;
  logic            alert;

  logic [CntW-1:0] c_cnt;
  logic [PtrW-1:0] c_head, c_head1, c_pos;
  logic [PtrW:0]   pos_sum;
  logic [StW-1:0]  st;

  assign st     = cur_q.station;
  assign c_cnt  = cnt_q[st];
  assign c_head = head_q[st];
  assign c_head1 = (c_head == PtrW'(RingSize - 1)) ? '0 : c_head + 1'b1;

  always_comb begin
    pos_sum = (PtrW+1)'(drop_q ? c_head1 : c_head) + (PtrW+1)'(ncnt_q - 1'b1);
    if (pos_sum >= (PtrW+1)'(RingSize)) begin
      pos_sum = pos_sum - (PtrW+1)'(RingSize);
    end
    c_pos = pos_sum[PtrW-1:0];
  end

  // The read address (oldest sample) is used in BK_READ; the write in BK_WAIT.
  always_comb begin
    mem_addr = MemAw'(32'(st) * RingSize + 32'(state_q == BK_READ ? c_head : c_pos));
  end
  assign mem_we = (state_q == BK_WAIT);

  baa_ram #(.Width(SmpW), .Depth(MemDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(cur_q.sample),
    .rdata_o(mem_rdata)
  );

  assign new_sum = sum_q[st] + SumW'(cur_q.sample)
                 - (drop_q ? SumW'($signed(mem_rdata)) : '0);
  assign div_start = (state_q == BK_WAIT);

  baa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (new_sum),
    .den_i  (ncnt_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign alert = (ncnt_q >= CntW'(WindowLimit)) && (quot < threshold_i);

  always_comb begin
    state_d    = state_q;
    work_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (work_valid_i && !(out_valid_o && out_stall_i)) begin
          work_pop_o = 1'b1;
          state_d    = BK_READ;
        end
      end
      BK_READ: state_d = cur_q.in_range ? BK_WAIT : BK_DONE;
      BK_WAIT: state_d = BK_DIV;
      BK_DIV:  if (div_done) state_d = BK_DONE;
      BK_DONE: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_o <= 1'b0;
      flag_q      <= '0;
      for (int i = 0; i < NumStations; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == BK_WAIT) begin
        sum_q[st]  <= new_sum;
        cnt_q[st]  <= ncnt_q;
        head_q[st] <= nhead_q;
      end
      if (state_q == BK_DONE) begin
        out_valid_o <= 1'b1;
        if (cur_q.in_range) begin
          flag_q[st] <= alert;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      cur_q <= work_i;
    end
    if (state_q == BK_READ) begin
      drop_q  <= (c_cnt > CntW'(WindowLimit));
      ncnt_q  <= (c_cnt > CntW'(WindowLimit)) ? c_cnt : c_cnt + 1'b1;
      nhead_q <= (c_cnt > CntW'(WindowLimit)) ? c_head1 : c_head;
    end
    if (state_q == BK_DONE) begin
      station_out_o <= st;
      if (cur_q.in_range) begin
        average_o   <= quot;
        low_alert_o <= alert;
        if (alert && !flag_q[st]) begin
          notice_o <= NOTICE_LOW;
        end else if (!alert && flag_q[st]) begin
          notice_o <= NOTICE_OK;
        end else begin
          notice_o <= NOTICE_NONE;
        end
      end else begin
        average_o   <= '0;
        low_alert_o <= 1'b0;
        notice_o    <= NOTICE_NONE;
      end
    end
  end
endmodule

### sv/battery_average_alarm_core.sv
// Battery average alarm: one result word per sample word. In the back end
// each sample is taken from the queue, the oldest sample is read, the store
// is updated and the divider started, the bit-serial divider forms the window
// average (25 quotient bits) and the result register is loaded; a word for an
// out-of-range station skips the update and the divider. A held result blocks
// the next word from leaving the queue; the front queue holds two words.
// Depends on baa_pkg, baa_front, baa_back and the macros header.
`include "battery_average_alarm_core_macros.svh"

module battery_average_alarm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         station_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         station_out_o,
  output logic signed [15:0] average_o,
  output logic               low_alert_o,
  output logic [1:0]         notice_o
);
  import baa_pkg::*;

  logic signed [SmpW-1:0] thr_q;
  logic  work_valid, work_pop;
  work_t work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  baa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .station_i   (station_i),
    .sample_i    (sample_i),
    .work_valid_o(work_valid),
    .work_pop_i  (work_pop),
    .work_o      (work)
  );

  baa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (thr_q),
    .work_valid_i (work_valid),
    .work_pop_o   (work_pop),
    .work_i       (work),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .station_out_o(station_out_o),
    .average_o    (average_o),
    .low_alert_o  (low_alert_o),
    .notice_o     (notice_o)
  );

  `BAA_ASSERT(a_pop_valid, !work_pop || work_valid, "pop from empty queue")
  `BAA_ASSERT(a_notice_code, notice_o != 2'd3 || !out_valid_o, "bad notice code")
  `BAA_ASSERT(a_notice_alert, !out_valid_o || notice_o != NOTICE_LOW || low_alert_o,
    "low notice without alert")
  `BAA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(average_o),
    "stalled result changed")
endmodule

### bench/battery_average_alarm_core_tb.sv
// Self-checking bench for the battery average alarm core: a queue-fed driver,
// a predictor of the per-station window average and notice logic, and a monitor.
// Depends on baa_pkg and the core.
module battery_average_alarm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import baa_pkg::*;

  typedef struct packed {
    logic [3:0]         station;
    logic signed [15:0] sample;
  } word_t;

  typedef struct packed {
    logic [3:0]         station;
    logic signed [15:0] average;
    logic               low_alert;
    notice_e            notice;
  } alarm_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic signed [15:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         station_i = '0;
  logic signed [15:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         station_out_o;
  logic signed [15:0] average_o;
  logic               low_alert_o;
  logic [1:0]         notice_o;

  battery_average_alarm_core u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [15:0] threshold;
  logic signed [15:0] ring [NumStations][RingSize];
  int                 win_sum [NumStations];
  int unsigned        win_cnt [NumStations];
  int unsigned        win_head [NumStations];
  bit                 notified [NumStations];

  word_t  pending_words [$];
  alarm_t expected_alarms [$];
  int     errors = 0;
  int     cycles = 0;
  bit     no_idle = 1'b0;
  int     hold_off = 0;
  bit     do_hold = 1'b0;

  function automatic alarm_t predict_alarm(word_t w);
    alarm_t r;
    int unsigned st, cnt, head;
    int old, avg;
    st = w.station;
    cnt = win_cnt[st];
    head = win_head[st];
    old = 0;
    if (cnt > WindowLimit) begin
      old = ring[st][head];
      head = (head + 1) % RingSize;
      cnt--;
    end
    ring[st][(head + cnt) % RingSize] = w.sample;
    cnt++;
    win_sum[st] = win_sum[st] + int'(w.sample) - old;
    win_cnt[st] = cnt;
    win_head[st] = head;
    avg = win_sum[st] / int'(cnt);
    r.station = w.station;
    r.average = avg[15:0];
    r.low_alert = (cnt >= WindowLimit) && (avg < int'(threshold));
    r.notice = NOTICE_NONE;
    if (r.low_alert) begin
      if (!notified[st]) begin
        notified[st] = 1'b1;
        r.notice = NOTICE_LOW;
      end
    end else if (notified[st]) begin
      notified[st] = 1'b0;
      r.notice = NOTICE_OK;
    end
    return r;
  endfunction

  // Driver: an item leaves the queue only when it is accepted.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && !in_stall_o) begin
      expected_alarms.push_back(predict_alarm(pending_words.pop_front()));
    end
    if (pending_words.size() > 0 && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i && !in_stall_o && pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (no_idle || $urandom_range(99) >= 38) begin
        in_valid_i <= 1'b1;
        station_i <= pending_words[0].station;
        sample_i <= pending_words[0].sample;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor and receiver stall, with one long hold-off on request.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_alarms.size() == 0) begin
        $error("unexpected result word station=%0d", station_out_o);
        errors++;
      end else begin
        alarm_t e;
        e = expected_alarms.pop_front();
        if (station_out_o !== e.station) begin
          $error("station_out expected %0d actual %0d", e.station, station_out_o);
          errors++;
        end
        if (average_o !== e.average) begin
          $error("average expected %0d actual %0d", e.average, average_o);
          errors++;
        end
        if (low_alert_o !== e.low_alert) begin
          $error("low_alert expected %0d actual %0d", e.low_alert, low_alert_o);
          errors++;
        end
        if (notice_o !== e.notice) begin
          $error("notice expected %0d actual %0d", e.notice, notice_o);
          errors++;
        end
      end
    end
    if (do_hold && hold_off == 0) begin
      hold_off <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      hold_off <= 0;
      out_stall_i <= !no_idle && ($urandom_range(99) < 38);
    end
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_word(int st, int smp);
    word_t w;
    w.station = st[3:0];
    w.sample = smp[15:0];
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_alarms.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_threshold(int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[15:0];
    threshold = value[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A long run of one station fills its window so alerts and notices occur.
  task automatic add_window_run(int st, int n, int centre, int spread);
    for (int i = 0; i < n; i++)
      add_word(st, centre + $urandom_range(2 * spread) - spread);
  endtask

  initial begin
    int th;
    threshold = ThresholdReset;
    for (int s = 0; s < NumStations; s++) begin
      win_sum[s] = 0;
      win_cnt[s] = 0;
      win_head[s] = 0;
      notified[s] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of sample and station under the reset threshold.
    add_word(0, 32767);
    add_word(0, -32768);
    add_word(15, -32768);
    add_word(15, -32768);
    add_word(15, 32767);
    add_word(7, 0);
    add_word(8, -1);
    add_word(8, 1);
    add_word(3, 2399);
    add_word(3, 2400);
    drain();

    // Fill station 5 below threshold, then recover: low then ok notices,
    // and the window grows past the limit so the oldest sample gets dropped.
    no_idle = 1'b1;
    add_window_run(5, 365, 2000, 50);
    add_window_run(5, 40, 30000, 100);
    drain();
    no_idle = 1'b0;

    // Extreme thresholds, plus a long receiver hold-off while input keeps coming.
    // The request stays set until the monitor is sure to have seen it.
    set_threshold(32767);
    add_window_run(6, 370, -32768, 0);
    do_hold = 1'b1;
    add_window_run(9, 20, 100, 100);
    repeat (2) @(posedge clk_i);
    do_hold = 1'b0;
    drain();
    set_threshold(-32768);
    add_window_run(6, 20, -32768, 0);
    drain();

    // Random phases: mostly per-station runs crossing a random threshold.
    for (int phase = 0; phase < 6; phase++) begin
      th = $urandom_range(65535) - 32768;
      if (phase == 0) th = 2400;
      set_threshold(th);
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(3) == 0)
          add_word($urandom_range(15), $urandom_range(65535) - 32768);
        else
          add_window_run($urandom_range(15), $urandom_range(60),
                         th + $urandom_range(2000) - 1000, $urandom_range(3000));
      end
      for (int i = 0; i < 60; i++)
        add_word($urandom_range(15), $urandom_range(65535) - 32768);
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/baa_pkg.sv
sv/baa_ram.sv
sv/baa_front.sv
sv/baa_div.sv
sv/baa_back.sv
sv/battery_average_alarm_core.sv
bench/battery_average_alarm_core_tb.sv
